/* hdl/csi_pkg.sv */
// Shared widths, stage types and helpers for the segment/circle crossing test.
package csi_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int RSQ_W      = 2 * COORD_BITS;
  localparam int MAG_W      = 2 * COORD_BITS + 1;
  localparam int LO_W       = (MAG_W + 1) / 2;
  localparam int HI_W       = MAG_W - LO_W;
  localparam int WIDE_W     = 2 * MAG_W;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] fx;
    logic signed [DIFF_W-1:0] fy;
    logic signed [DIFF_W-1:0] ex;
    logic signed [DIFF_W-1:0] ey;
    logic [COORD_BITS-1:0]    r;
  } diff_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] a;
    logic signed [SUM_W-1:0] h;
    logic signed [SUM_W-1:0] c0;
    logic signed [SUM_W-1:0] c1;
  } quad_t;

  function automatic logic signed [DIFF_W-1:0] sx(input logic [COORD_BITS-1:0] v);
    return $signed({v[COORD_BITS-1], v});
  endfunction

endpackage

/* hdl/csi_quad.sv */
// Products and sums of the quadratic coefficients (two register stages).
module csi_quad
  import csi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  diff_t in_diff,
  output logic  out_valid,
  output quad_t out_quad
);

  logic                     v2;
  logic signed [PROD_W-1:0] dxx, dyy, dfx, dfy, fxx, fyy, exx, eyy;
  logic [RSQ_W-1:0]         rr;
  logic signed [SUM_W-1:0]  rr_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dxx <= in_diff.dx * in_diff.dx;
    dyy <= in_diff.dy * in_diff.dy;
    dfx <= in_diff.dx * in_diff.fx;
    dfy <= in_diff.dy * in_diff.fy;
    fxx <= in_diff.fx * in_diff.fx;
    fyy <= in_diff.fy * in_diff.fy;
    exx <= in_diff.ex * in_diff.ex;
    eyy <= in_diff.ey * in_diff.ey;
    rr  <= in_diff.r * in_diff.r;
  end

  assign rr_s = $signed(SUM_W'(rr));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    out_quad.a  <= SUM_W'(dxx) + SUM_W'(dyy);
    out_quad.h  <= SUM_W'(dfx) + SUM_W'(dfy);
    out_quad.c0 <= SUM_W'(fxx) + SUM_W'(fyy) - rr_s;
    out_quad.c1 <= SUM_W'(exx) + SUM_W'(eyy) - rr_s;
  end

endmodule

/* hdl/csi_disc.sv */
// Discriminant compare by split products and root range tests (three stages).
module csi_disc
  import csi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  quad_t in_quad,
  output logic  done,
  output logic  hit
);

  logic [SUM_W-1:0]       h_neg;
  logic [MAG_W-1:0]       h_mag, a_mag, c_mag;
  logic signed [SUM_W:0]  ha;
  logic                   h_le0, c0_ge0, c0_le0, c0_pos, c1_le0, c1_ge0;
  logic                   ha_gt0, ha_ge0, t1, t2;

  logic                   v4, ok4;
  logic [2*HI_W-1:0]      ph_hh, pa_hh;
  logic [HI_W+LO_W-1:0]   ph_hl, pa_hl, pa_lh;
  logic [2*LO_W-1:0]      ph_ll, pa_ll;

  logic                   v5, ok5;
  logic [WIDE_W-1:0]      hsq5, ac5;

  always_comb begin
    h_neg  = -in_quad.h;
    h_mag  = in_quad.h[SUM_W-1] ? h_neg[MAG_W-1:0] : in_quad.h[MAG_W-1:0];
    a_mag  = in_quad.a[MAG_W-1:0];
    c0_le0 = in_quad.c0[SUM_W-1] || (in_quad.c0 == '0);
    c0_ge0 = !in_quad.c0[SUM_W-1];
    c0_pos = !c0_le0;
    c_mag  = c0_pos ? in_quad.c0[MAG_W-1:0] : '0;
    c1_le0 = in_quad.c1[SUM_W-1] || (in_quad.c1 == '0);
    c1_ge0 = !in_quad.c1[SUM_W-1];
    h_le0  = in_quad.h[SUM_W-1] || (in_quad.h == '0);
    ha     = (SUM_W+1)'(in_quad.h) + (SUM_W+1)'(in_quad.a);
    ha_ge0 = !ha[SUM_W];
    ha_gt0 = ha_ge0 && (ha != '0);
    t1     = h_le0 && c0_ge0 && (ha_gt0 || c1_le0);
    t2     = (h_le0 || c0_le0) && ha_ge0 && c1_ge0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      done <= 1'b0;
    end else begin
      v4 <= in_valid;
      v5 <= v4;
      done <= v5;
    end
  end

  always_ff @(posedge clk) begin
    ok4   <= (in_quad.a != '0) && (t1 || t2);
    ph_hh <= h_mag[MAG_W-1:LO_W] * h_mag[MAG_W-1:LO_W];
    ph_hl <= h_mag[MAG_W-1:LO_W] * h_mag[LO_W-1:0];
    ph_ll <= h_mag[LO_W-1:0] * h_mag[LO_W-1:0];
    pa_hh <= a_mag[MAG_W-1:LO_W] * c_mag[MAG_W-1:LO_W];
    pa_hl <= a_mag[MAG_W-1:LO_W] * c_mag[LO_W-1:0];
    pa_lh <= a_mag[LO_W-1:0] * c_mag[MAG_W-1:LO_W];
    pa_ll <= a_mag[LO_W-1:0] * c_mag[LO_W-1:0];
  end

  always_ff @(posedge clk) begin
    ok5  <= ok4;
    hsq5 <= (WIDE_W'(ph_hh) << (2 * LO_W)) + (WIDE_W'(ph_hl) << (LO_W + 1))
            + WIDE_W'(ph_ll);
    ac5  <= (WIDE_W'(pa_hh) << (2 * LO_W))
            + ((WIDE_W'(pa_hl) + WIDE_W'(pa_lh)) << LO_W) + WIDE_W'(pa_ll);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= v5 && ok5 && (hsq5 >= ac5);
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(v5))
    else $error("result strobe without a valid item in the compare stage");
  assert property (@(posedge clk) disable iff (rst) hit |-> done)
    else $error("hit raised outside a result transfer");
  assert property (@(posedge clk) disable iff (rst) v5 && !ok5 |=> !hit)
    else $error("hit despite failed root range test");
  assert property (@(posedge clk) disable iff (rst) v5 && (hsq5 < ac5) |=> !hit)
    else $error("hit despite negative discriminant");

endmodule

/* hdl/segment_circle_intersect_test.sv */
// Top level of the segment/circle crossing test: input differences and pipeline.
//
// Command channel: drive the segment endpoints, circle center and radius and
// raise start; the item transfers at the rising edge where start is high and
// busy is low. busy is high only while rst is high, so outside reset one item
// may transfer in every cycle.
// Result channel: done is high for exactly one cycle per item, with hit valid
// in that same cycle; results leave in the order the items arrived.
// Pipeline: the item passes the difference stage, product stage, coefficient
// sum stage, split discriminant product stage, wide sum stage and compare
// stage in that order; done and hit are registered in the compare stage.
// Throughput: one item per cycle; every stage is a plain register with no
// feedback, and the 66-bit discriminant products are formed from partial
// products of 17-bit and 16-bit halves in one stage and summed in the next.
// Reset: rst clears all stage valid bits synchronously; items in flight are
// dropped and no done pulse follows. busy is high while rst is high, so no
// item transfers during reset.
// The receiver cannot stall: done is a strobe and the pipeline never holds.
module segment_circle_intersect_test
  import csi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] seg_start_x,
  input  logic [COORD_BITS-1:0] seg_start_y,
  input  logic [COORD_BITS-1:0] seg_end_x,
  input  logic [COORD_BITS-1:0] seg_end_y,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic [COORD_BITS-1:0] radius,
  output logic                  done,
  output logic                  hit
);

  logic  v1;
  diff_t d1;
  logic  v3;
  quad_t q3;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    d1.dx <= sx(seg_end_x) - sx(seg_start_x);
    d1.dy <= sx(seg_end_y) - sx(seg_start_y);
    d1.fx <= sx(seg_start_x) - sx(center_x);
    d1.fy <= sx(seg_start_y) - sx(center_y);
    d1.ex <= sx(seg_end_x) - sx(center_x);
    d1.ey <= sx(seg_end_y) - sx(center_y);
    d1.r  <= radius;
  end

  csi_quad u_quad (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_diff   (d1),
    .out_valid (v3),
    .out_quad  (q3)
  );

  csi_disc u_disc (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .in_quad  (q3),
    .done     (done),
    .hit      (hit)
  );

endmodule
